// File: sv/rbt_pkg.sv
// Shared types and constants for the range breakpoint table.
package rbt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COVERED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;   // latch request and per-entry cover flags
    logic execute;   // update table and load result register
  } cmd_t;

endpackage

// File: sv/range_breakpoint_table.sv
// Top level of the range breakpoint table: controller plus datapath.
//
// Ordered table of up to rbt_pkg::TABLE_DEPTH address-range breakpoints. An
// entry covers start through start+length inclusive (the end wraps modulo
// 2^64; a wrapped entry covers nothing). Op add appends unless the address is
// already covered (status 1) or the table is full (status 3); op delete drops
// the first covering entry and shifts later ones down; op find returns the
// kind of the first covering entry; a miss answers status 2. Each request
// produces exactly one result. A request is handled in two steps: in the
// accept cycle every stored entry is compared against the address in
// parallel and the cover flags are registered; once the result register is
// free or being drained, the first match is picked, the table is updated and
// the result register is loaded. No new request is taken before the last has
// executed. A new request is taken while an earlier result is still waiting.
// Entry storage needs no clearing after reset; only the entry count resets.
module range_breakpoint_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  op,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic        kind,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  status,
  output logic        hit,
  output logic        hit_kind
);
  import rbt_pkg::*;

  cmd_t cmd;

  // sequence capture and execute, own the result valid flag
  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd)
  );

  // hold entries, compare, update and drive the result fields
  rbt_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op       (op),
    .address  (address),
    .length   (length),
    .kind     (kind),
    .status   (status),
    .hit      (hit),
    .hit_kind (hit_kind)
  );

endmodule

// File: sv/rbt_ctrl.sv
// Controller state machine sequencing capture and execute of each request.
module rbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_ready,
  output rbt_pkg::cmd_t cmd
);
  import rbt_pkg::*;

  state_t state;
  state_t state_next;
  logic   res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd.capture    = 1'b0;
    cmd.execute    = 1'b0;
    res_valid_next = res_valid && !res_ready;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free or being drained
        if (!res_valid || res_ready) begin
          cmd.execute    = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/rbt_dpath.sv
// Datapath: entry storage, parallel cover compare, update and result register.
module rbt_dpath (
  input  logic          clk,
  input  logic          rst,
  input  rbt_pkg::cmd_t cmd,
  input  logic [1:0]    op,
  input  logic [63:0]   address,
  input  logic [63:0]   length,
  input  logic          kind,
  output logic [1:0]    status,
  output logic          hit,
  output logic          hit_kind
);
  import rbt_pkg::*;

  logic [ADDR_W-1:0]      entry_start [TABLE_DEPTH];
  logic [ADDR_W-1:0]      entry_end   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_kind;
  logic [CNT_W-1:0]       entry_count;

  op_t                    op_q;
  logic [ADDR_W-1:0]      start_q;
  logic [ADDR_W-1:0]      end_q;
  logic                   kind_q;
  logic [TABLE_DEPTH-1:0] cover_q;

  logic [TABLE_DEPTH-1:0] cover_next;
  logic [TABLE_DEPTH-1:0] prefix;
  logic [TABLE_DEPTH-1:0] first;
  logic                   any_cover;
  logic                   full;
  logic                   do_add;
  logic                   do_del;
  status_t                status_next;
  logic                   hit_next;
  logic                   hit_kind_next;

  // cover test against live entries; a wrapped end never matches
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      cover_next[j] = (entry_count > CNT_W'(j)) &&
                      (address >= entry_start[j]) && (address <= entry_end[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(op);
      start_q <= address;
      end_q   <= address + length;
      kind_q  <= kind;
      cover_q <= cover_next;
    end
  end

  // prefix[j] set at and above the first covering entry
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      prefix[j] = |(cover_q << (TABLE_DEPTH - 1 - j));
    end
    first     = cover_q & ~(prefix << 1);
    any_cover = |cover_q;
    full      = (entry_count == CNT_W'(TABLE_DEPTH));
  end

  always_comb begin
    status_next   = ST_OK;
    hit_next      = 1'b0;
    hit_kind_next = 1'b0;
    do_add        = 1'b0;
    do_del        = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (any_cover) begin
          status_next = ST_COVERED;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_add = 1'b1;
        end
      end
      OP_DELETE: begin
        if (any_cover) begin
          hit_next = 1'b1;
          do_del   = 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (any_cover) begin
          hit_next      = 1'b1;
          hit_kind_next = |(first & entry_kind);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // append at the tail, or close the gap left by a delete
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (do_add && (entry_count == CNT_W'(j))) begin
          entry_start[j] <= start_q;
          entry_end[j]   <= end_q;
          entry_kind[j]  <= kind_q;
        end else if (do_del && prefix[j] && (j + 1 < TABLE_DEPTH)) begin
          entry_start[j] <= entry_start[(j + 1) % TABLE_DEPTH];
          entry_end[j]   <= entry_end[(j + 1) % TABLE_DEPTH];
          entry_kind[j]  <= entry_kind[(j + 1) % TABLE_DEPTH];
        end
      end
      status   <= status_next;
      hit      <= hit_next;
      hit_kind <= hit_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.execute) begin
      if (do_add) begin
        entry_count <= entry_count + CNT_W'(1);
      end else if (do_del) begin
        entry_count <= entry_count - CNT_W'(1);
      end
    end
  end

endmodule
